>>> rtl/core/mte_pkg.sv
// shared types and constants of the midi track event encoder
`default_nettype none

package mte_pkg;

  // action codes of an input item
  typedef enum logic [2:0] {
    ACT_NOTE_ON  = 3'd0,
    ACT_NOTE_OFF = 3'd1,
    ACT_PROGRAM  = 3'd2,
    ACT_CONTROL  = 3'd3,
    ACT_TEMPO    = 3'd4,
    ACT_END      = 3'd5
  } mte_action_t;

  // status and meta bytes
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_PROGRAM  = 8'hC0;
  localparam logic [7:0] ST_CONTROL  = 8'hB0;
  localparam logic [7:0] META_PREFIX = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] TEMPO_LEN   = 8'h03;
  localparam logic [6:0] DATA_MASK   = 7'h7F;

  localparam int unsigned VLQ_MAX = 5;
  localparam int unsigned EVT_MAX = 6;

  // one encoded event: delta bytes first, then event bytes, index 0 sent first
  typedef struct packed {
    logic [VLQ_MAX-1:0][7:0] vlq;
    logic [2:0]              vlq_n;
    logic [EVT_MAX-1:0][7:0] evt;
    logic [2:0]              evt_n;
  } mte_frame_t;

endpackage

`default_nettype wire

>>> rtl/core/mte_encode.sv
// encode stage: delta time, variable-length quantity and event bytes into a frame register
`default_nettype none

module mte_encode (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_action,
  input  wire logic [31:0]        in_event_tick,
  input  wire logic [3:0]         in_midi_channel,
  input  wire logic [7:0]         in_first_data,
  input  wire logic [7:0]         in_second_data,
  input  wire logic [23:0]        in_tempo_us,
  input  wire logic               frame_take,
  output logic                    frame_vld,
  output mte_pkg::mte_frame_t     frame
);
  import mte_pkg::*;

  logic [31:0]       prev_tick_r, prev_tick_nxt;
  logic              frame_vld_r, frame_vld_nxt;
  mte_frame_t        frame_r, frame_nxt;
  logic              accept;
  logic              known;
  logic [31:0]       delta;
  logic [VLQ_MAX-1:0][6:0] grp;
  logic [2:0]        vlq_n;
  logic [2:0]        gi;
  logic [7:0]        d1;
  logic [7:0]        d2;

  // handshake
  assign in_stall = frame_vld_r && !frame_take;
  assign accept   = in_valid && !in_stall;
  assign known    = (in_action <= ACT_END);

  // delta split into 7-bit groups, least significant first
  assign delta = in_event_tick - prev_tick_r;
  assign grp[0] = delta[6:0];
  assign grp[1] = delta[13:7];
  assign grp[2] = delta[20:14];
  assign grp[3] = delta[27:21];
  assign grp[4] = {3'b000, delta[31:28]};

  // number of groups needed
  always_comb begin
    if (delta[31:28] != 4'd0) begin
      vlq_n = 3'd5;
    end else if (delta[27:21] != 7'd0) begin
      vlq_n = 3'd4;
    end else if (delta[20:14] != 7'd0) begin
      vlq_n = 3'd3;
    end else if (delta[13:7] != 7'd0) begin
      vlq_n = 3'd2;
    end else begin
      vlq_n = 3'd1;
    end
  end

  assign d1 = {1'b0, in_first_data[6:0] & DATA_MASK};
  assign d2 = {1'b0, in_second_data[6:0] & DATA_MASK};

  // frame contents
  always_comb begin
    frame_nxt = '0;
    gi        = '0;
    // big-endian groups, continuation bit on all but the final one
    for (int j = 0; j < VLQ_MAX; j++) begin
      gi = 3'(vlq_n - 3'(j) - 3'd1);
      if (3'(j) < vlq_n) begin
        frame_nxt.vlq[j] = {(3'(j) != 3'(vlq_n - 3'd1)), grp[gi]};
      end
    end
    frame_nxt.vlq_n = vlq_n;
    case (in_action)
      ACT_NOTE_ON: begin
        frame_nxt.evt[0] = ST_NOTE_ON | {4'h0, in_midi_channel};
        frame_nxt.evt[1] = d1;
        frame_nxt.evt[2] = d2;
        frame_nxt.evt_n  = 3'd3;
      end
      ACT_NOTE_OFF: begin
        frame_nxt.evt[0] = ST_NOTE_OFF | {4'h0, in_midi_channel};
        frame_nxt.evt[1] = d1;
        frame_nxt.evt[2] = 8'h00;
        frame_nxt.evt_n  = 3'd3;
      end
      ACT_PROGRAM: begin
        frame_nxt.evt[0] = ST_PROGRAM | {4'h0, in_midi_channel};
        frame_nxt.evt[1] = d1;
        frame_nxt.evt_n  = 3'd2;
      end
      ACT_CONTROL: begin
        frame_nxt.evt[0] = ST_CONTROL | {4'h0, in_midi_channel};
        frame_nxt.evt[1] = d1;
        frame_nxt.evt[2] = d2;
        frame_nxt.evt_n  = 3'd3;
      end
      ACT_TEMPO: begin
        frame_nxt.evt[0] = META_PREFIX;
        frame_nxt.evt[1] = META_TEMPO;
        frame_nxt.evt[2] = TEMPO_LEN;
        frame_nxt.evt[3] = in_tempo_us[23:16];
        frame_nxt.evt[4] = in_tempo_us[15:8];
        frame_nxt.evt[5] = in_tempo_us[7:0];
        frame_nxt.evt_n  = 3'd6;
      end
      default: begin
        // end of track: zero delta, then the end-of-track meta event
        frame_nxt.vlq    = '0;
        frame_nxt.vlq_n  = 3'd1;
        frame_nxt.evt[0] = META_PREFIX;
        frame_nxt.evt[1] = META_EOT;
        frame_nxt.evt[2] = 8'h00;
        frame_nxt.evt_n  = 3'd3;
      end
    endcase
  end

  // tick memory and frame valid
  always_comb begin
    prev_tick_nxt = prev_tick_r;
    frame_vld_nxt = frame_vld_r;
    if (frame_take) begin
      frame_vld_nxt = 1'b0;
    end
    if (accept && known) begin
      frame_vld_nxt = 1'b1;
      prev_tick_nxt = (in_action == ACT_END) ? 32'd0 : in_event_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r <= '0;
      frame_vld_r <= 1'b0;
    end else begin
      prev_tick_r <= prev_tick_nxt;
      frame_vld_r <= frame_vld_nxt;
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (accept && known) begin
      frame_r <= frame_nxt;
    end
  end

  assign frame_vld = frame_vld_r;
  assign frame     = frame_r;

endmodule

`default_nettype wire

>>> rtl/core/mte_serialize.sv
// output stage: sends a frame one byte per cycle while out_stall is low and flags the final byte
`default_nettype none

module mte_serialize (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               frame_vld,
  input  wire mte_pkg::mte_frame_t frame,
  output logic                    frame_take,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last_byte
);
  import mte_pkg::*;

  logic       ser_vld_r, ser_vld_nxt;
  logic [3:0] ser_idx_r, ser_idx_nxt;
  mte_frame_t ser_frame_r;
  logic [3:0] total;
  logic [3:0] evt_idx;
  logic       last;
  logic       out_acc;
  logic       load;

  assign total   = {1'b0, ser_frame_r.vlq_n} + {1'b0, ser_frame_r.evt_n};
  assign last    = (ser_idx_r == 4'(total - 4'd1));
  assign out_acc = ser_vld_r && !out_stall;
  assign load    = frame_vld && (!ser_vld_r || (out_acc && last));
  assign evt_idx = ser_idx_r - {1'b0, ser_frame_r.vlq_n};

  // byte select: delta bytes, then event bytes
  always_comb begin
    if (ser_idx_r < {1'b0, ser_frame_r.vlq_n}) begin
      out_byte = ser_frame_r.vlq[ser_idx_r[2:0]];
    end else begin
      out_byte = ser_frame_r.evt[evt_idx[2:0]];
    end
  end

  // index and valid
  always_comb begin
    ser_vld_nxt = ser_vld_r;
    ser_idx_nxt = ser_idx_r;
    if (load) begin
      ser_vld_nxt = 1'b1;
      ser_idx_nxt = 4'd0;
    end else if (out_acc) begin
      if (last) begin
        ser_vld_nxt = 1'b0;
      end else begin
        ser_idx_nxt = ser_idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      ser_idx_r <= '0;
    end else begin
      ser_vld_r <= ser_vld_nxt;
      ser_idx_r <= ser_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_frame_r <= frame;
    end
  end

  assign frame_take    = load;
  assign out_valid     = ser_vld_r;
  assign out_last_byte = last;

endmodule

`default_nettype wire

>>> rtl/core/midi_track_event_encoder.sv
// top level of the midi track event encoder
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   action, event_tick, midi_channel,
//                                             first_data, second_data, tempo_us
//   out_     output     out_valid / out_stall out_byte, out_last_byte
//
// An event leaves as 3 to 11 bytes, one byte per cycle at the output port while
// out_stall is low (delta 1..5 plus event 2..6; end of track 4). The first byte
// passes the frame register and then the serializer's register before it shows.
// A frame register between encoder and serializer takes the next item while the
// current one is still sent. Unknown actions are accepted and give no bytes.
// rst_n is synchronous and clears the remembered tick and all valid flags.
// out_stall holds the current byte; in_stall rises only when the frame register
// is full and cannot move on.
`default_nettype none

module midi_track_event_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_event_tick,
  input  wire logic [3:0]  in_midi_channel,
  input  wire logic [7:0]  in_first_data,
  input  wire logic [7:0]  in_second_data,
  input  wire logic [23:0] in_tempo_us,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);
  import mte_pkg::*;

  logic       frame_vld;
  logic       frame_take;
  mte_frame_t frame;

  // delta and event encoding
  mte_encode u_encode (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_event_tick   (in_event_tick),
    .in_midi_channel (in_midi_channel),
    .in_first_data   (in_first_data),
    .in_second_data  (in_second_data),
    .in_tempo_us     (in_tempo_us),
    .frame_take      (frame_take),
    .frame_vld       (frame_vld),
    .frame           (frame)
  );

  // byte serializer
  mte_serialize u_serialize (
    .clk           (clk),
    .rst_n         (rst_n),
    .frame_vld     (frame_vld),
    .frame         (frame),
    .frame_take    (frame_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

`ifndef SYNTHESIS
  // a known action always yields a pending frame
  a_frame_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action <= ACT_END) |=> frame_vld)
    else $error("accepted event left no frame");

  // frame byte counts stay in their legal ranges
  a_frame_counts: assert property (@(posedge clk) disable iff (!rst_n)
    frame_vld |-> (frame.vlq_n >= 3'd1) && (frame.vlq_n <= 3'd5) &&
                  (frame.evt_n >= 3'd2) && (frame.evt_n <= 3'd6))
    else $error("frame byte count out of range");

  // output goes idle after a final byte when nothing is pending
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_byte && !frame_vld |=> !out_valid)
    else $error("output still valid after final byte");

  // a frame is only taken when present
  a_take_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    frame_take |-> frame_vld)
    else $error("frame taken while empty");
`endif

endmodule

`default_nettype wire
